/* rtl/pwts_pkg.sv */
// ----------------------------------------------------------------------------
// pwts_pkg
// Types and constants shared by the per-window traffic statistics block.
// ----------------------------------------------------------------------------
package pwts_pkg;

  localparam int ELAPSED_W = 52;
  localparam int WLEN_W    = 26;
  localparam int FIFO_DEPTH = 4;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 26'd1000000;
  localparam logic [19:0]       US_PER_SEC = 20'd1000000;

  typedef struct packed {
    logic        kind;
    logic [31:0] ts_seconds;
    logic [19:0] ts_micros;
    logic [15:0] pkt_len;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
  } in_word_t;

  typedef struct packed {
    logic [31:0] window_index;
    logic [31:0] packet_count;
    logic [31:0] byte_total;
    logic [23:0] mean_length_q8;
    logic [25:0] mean_gap_us;
    logic [8:0]  distinct_sources;
    logic [8:0]  distinct_destinations;
    logic [9:0]  distinct_addresses;
    logic        overflow;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_NEW,
    OP_FLUSH
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                op;
    logic [31:0]            win;
    logic [ELAPSED_W-1:0]   elapsed;
    logic [15:0]            pkt_len;
    logic [31:0]            src_ip;
    logic [31:0]            dst_ip;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t word;
  } q_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_SUM,
    F_CHK,
    F_DIV,
    F_CLASS,
    F_PUSH
  } fe_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DECODE,
    B_GAP_GO,
    B_GAP_WAIT,
    B_MEAN_GO,
    B_MEAN_WAIT,
    B_EMIT,
    B_CLEAR,
    B_ADD,
    B_SCAN
  } be_state_t;

endpackage

/* rtl/pwts_div.sv */
// ----------------------------------------------------------------------------
// pwts_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwts_div #(
  parameter int NW = 52,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvs_r;
  logic [NW-1:0] dvd_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [DW:0]   sh;
  logic          qbit;
  logic [DW:0]   sub;

  always_comb begin
    sh   = {rem_r, dvd_r[NW-1]};
    qbit = (sh >= {1'b0, dvs_r});
    sub  = sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(NW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      dvd_r <= dividend;
    end else if (run_r) begin
      rem_r <= qbit ? sub[DW-1:0] : sh[DW-1:0];
      dvd_r <= {dvd_r[NW-2:0], qbit};
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

/* rtl/pwts_fifo.sv */
// ----------------------------------------------------------------------------
// pwts_fifo
// Short command queue between the classifier and the statistics engine.
// ----------------------------------------------------------------------------
module pwts_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  pwts_pkg::q_wr_t  wr,
  input  logic             pop,
  output pwts_pkg::cmd_t   head,
  output pwts_pkg::q_stat_t stat
);
  import pwts_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int NW = $clog2(FIFO_DEPTH + 1);

  cmd_t          mem_r [FIFO_DEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [NW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign stat.full  = (cnt_r == NW'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = wr.push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PW'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == PW'(FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + NW'(do_push) - NW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr.word;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(FIFO_DEPTH)) else $error("queue count beyond depth");
  a_no_ovr: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !(wr.push && !pop)) else $error("push into full queue");
  a_no_udr: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && stat.empty) |=> $stable(rp_r)) else $error("pop from empty queue moved");

endmodule

/* rtl/pwts_front.sv */
// ----------------------------------------------------------------------------
// pwts_front
// Takes input words, computes elapsed time and window number, and queues
// add, new-window and flush commands.
// ----------------------------------------------------------------------------
module pwts_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pwts_pkg::in_word_t              in_word,
  input  logic                            cfg_we,
  input  logic [pwts_pkg::WLEN_W-1:0]     cfg_wdata,
  output pwts_pkg::q_wr_t                 q_wr,
  input  pwts_pkg::q_stat_t               q_stat
);
  import pwts_pkg::*;

  fe_state_t              state_r, state_nxt;
  logic [WLEN_W-1:0]      wlen_r;
  logic                   started_r;
  logic [31:0]            base_s_r;
  logic [19:0]            base_us_r;
  logic [31:0]            cur_win_r;
  in_word_t               item_r;
  logic signed [53:0]     mul_r;
  logic signed [20:0]     udiff_r;
  logic signed [53:0]     diff_r;
  cmd_t                   cmd_r;

  logic                   accept;
  logic signed [32:0]     sdiff;
  logic signed [20:0]     usec_s;
  logic signed [53:0]     mul_full;
  logic signed [20:0]     udiff;
  logic [WLEN_W-1:0]      wl;
  logic                   div_start;
  logic                   div_done;
  logic [ELAPSED_W-1:0]   q;
  logic [31:0]            win;

  assign accept = in_valid && !in_stall;

  always_comb begin
    sdiff    = $signed({1'b0, item_r.ts_seconds}) - $signed({1'b0, base_s_r});
    usec_s   = $signed({1'b0, US_PER_SEC});
    mul_full = sdiff * usec_s;
    udiff    = $signed({1'b0, item_r.ts_micros}) - $signed({1'b0, base_us_r});
    wl       = (wlen_r == '0) ? WLEN_W'(1) : wlen_r;
    win      = (|q[ELAPSED_W-1:32] || &q[31:0]) ? 32'hFFFF_FFFF : q[31:0] + 32'd1;
  end

  pwts_div #(.NW(ELAPSED_W), .DW(WLEN_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff_r[ELAPSED_W-1:0]),
    .divisor  (wl),
    .done     (div_done),
    .quotient (q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (accept) state_nxt = in_word.kind ? F_PUSH : F_MUL;
      F_MUL:   state_nxt = F_SUM;
      F_SUM:   state_nxt = F_CHK;
      F_CHK:   state_nxt = diff_r[53] ? F_IDLE : F_DIV;
      F_DIV:   if (div_done) state_nxt = F_CLASS;
      F_CLASS: state_nxt = (win < cur_win_r) ? F_IDLE : F_PUSH;
      F_PUSH:  if (!q_stat.full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != F_IDLE);
    div_start = (state_r == F_CHK) && !diff_r[53];
    q_wr.push = (state_r == F_PUSH) && !q_stat.full;
    q_wr.word = cmd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      wlen_r    <= WLEN_RESET;
      started_r <= 1'b0;
      base_s_r  <= '0;
      base_us_r <= '0;
      cur_win_r <= 32'd1;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) wlen_r <= cfg_wdata;
      if (accept) begin
        if (in_word.kind) begin
          started_r <= 1'b0;
          cur_win_r <= 32'd1;
        end else if (!started_r) begin
          started_r <= 1'b1;
          base_s_r  <= in_word.ts_seconds;
          base_us_r <= in_word.ts_micros;
          cur_win_r <= 32'd1;
        end
      end
      if (state_r == F_CLASS && win > cur_win_r) cur_win_r <= win;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r    <= in_word;
      cmd_r.op  <= OP_FLUSH;
    end
    if (state_r == F_MUL) begin
      mul_r   <= mul_full;
      udiff_r <= udiff;
    end
    if (state_r == F_SUM) diff_r <= mul_r + 54'(udiff_r);
    if (state_r == F_CLASS) begin
      cmd_r.op      <= (win == cur_win_r) ? OP_ADD : OP_NEW;
      cmd_r.win     <= win;
      cmd_r.elapsed <= diff_r[ELAPSED_W-1:0];
      cmd_r.pkt_len <= item_r.pkt_len;
      cmd_r.src_ip  <= item_r.src_ip;
      cmd_r.dst_ip  <= item_r.dst_ip;
    end
  end

endmodule

/* rtl/pwts_back.sv */
// ----------------------------------------------------------------------------
// pwts_back
// Statistics engine: counters, address sets, window close divisions and
// the output register.
// ----------------------------------------------------------------------------
module pwts_back #(
  parameter int SET_DEPTH   = 256,
  parameter int UNION_DEPTH = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pwts_pkg::cmd_t      head,
  input  pwts_pkg::q_stat_t   q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output pwts_pkg::out_word_t out_word
);
  import pwts_pkg::*;

  localparam int MAXD = (SET_DEPTH > UNION_DEPTH) ? SET_DEPTH : UNION_DEPTH;
  localparam int KW   = $clog2(MAXD + 1);
  localparam int SIW  = $clog2(SET_DEPTH);
  localparam int UIW  = $clog2(UNION_DEPTH);
  localparam int SUW  = $clog2(SET_DEPTH + 1);
  localparam int UUW  = $clog2(UNION_DEPTH + 1);

  be_state_t            state_r, state_nxt;
  cmd_t                 cmd_r;
  logic [31:0]          win_r;
  logic [31:0]          cnt_r;
  logic [31:0]          bytes_r;
  logic [ELAPSED_W-1:0] first_r;
  logic [ELAPSED_W-1:0] last_r;
  logic [SUW-1:0]       src_used_r;
  logic [SUW-1:0]       dst_used_r;
  logic [UUW-1:0]       uni_used_r;
  logic                 ovf_r;
  logic [25:0]          gap_r;
  logic [23:0]          mean_r;
  logic [1:0]           phase_r;
  logic [KW-1:0]        scan_k_r;
  logic                 rd_v_r;
  logic                 out_valid_r;
  out_word_t            out_word_r;

  logic [31:0]          src_mem [SET_DEPTH];
  logic [31:0]          dst_mem [SET_DEPTH];
  logic [31:0]          uni_mem [UNION_DEPTH];
  logic [31:0]          src_rd_r;
  logic [31:0]          dst_rd_r;
  logic [31:0]          uni_rd_r;

  logic [31:0]          key;
  logic [KW-1:0]        used_sel;
  logic [KW-1:0]        depth_sel;
  logic [31:0]          rd_sel;
  logic                 hit;
  logic                 more;
  logic                 issue;
  logic                 miss_done;
  logic                 ins;
  logic                 phase_end;
  logic                 gap_need;
  logic                 out_free;
  logic                 out_load;
  logic                 div_start;
  logic                 div_done;
  logic [ELAPSED_W-1:0] div_dvd;
  logic [31:0]          div_dvs;
  logic [ELAPSED_W-1:0] q;
  logic [32:0]          bsum;
  logic [31:0]          su32;
  logic [31:0]          du32;
  logic [31:0]          uu32;

  always_comb begin
    key = phase_r[0] ? cmd_r.dst_ip : cmd_r.src_ip;
    case (phase_r)
      2'd0:    begin used_sel = KW'(src_used_r); rd_sel = src_rd_r; end
      2'd1:    begin used_sel = KW'(dst_used_r); rd_sel = dst_rd_r; end
      default: begin used_sel = KW'(uni_used_r); rd_sel = uni_rd_r; end
    endcase
    depth_sel = phase_r[1] ? KW'(UNION_DEPTH) : KW'(SET_DEPTH);
    hit       = rd_v_r && (rd_sel == key);
    more      = scan_k_r < used_sel;
    gap_need  = (cnt_r > 32'd1) && (last_r > first_r);
    out_free  = !out_valid_r || !out_stall;
    bsum      = {1'b0, bytes_r} + 33'(cmd_r.pkt_len);
    su32      = 32'(src_used_r);
    du32      = 32'(dst_used_r);
    uu32      = 32'(uni_used_r);
  end

  pwts_div #(.NW(ELAPSED_W), .DW(32)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:      if (!q_stat.empty) state_nxt = B_DECODE;
      B_DECODE: begin
        if (cmd_r.op == OP_ADD)  state_nxt = B_ADD;
        else if (cnt_r != '0)    state_nxt = B_GAP_GO;
        else                     state_nxt = B_CLEAR;
      end
      B_GAP_GO:    state_nxt = gap_need ? B_GAP_WAIT : B_MEAN_GO;
      B_GAP_WAIT:  if (div_done) state_nxt = B_MEAN_GO;
      B_MEAN_GO:   state_nxt = B_MEAN_WAIT;
      B_MEAN_WAIT: if (div_done) state_nxt = B_EMIT;
      B_EMIT:      if (out_free) state_nxt = B_CLEAR;
      B_CLEAR:     state_nxt = (cmd_r.op == OP_FLUSH) ? B_IDLE : B_ADD;
      B_ADD:       state_nxt = B_SCAN;
      B_SCAN:      if (phase_end && phase_r == 2'd3) state_nxt = B_IDLE;
      default:     state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state_r == B_IDLE) && !q_stat.empty;
    issue     = (state_r == B_SCAN) && !hit && more;
    miss_done = (state_r == B_SCAN) && !hit && !more;
    ins       = miss_done && (used_sel < depth_sel);
    phase_end = (state_r == B_SCAN) && (hit || !more);
    out_load  = (state_r == B_EMIT) && out_free;
    div_start = ((state_r == B_GAP_GO) && gap_need) || (state_r == B_MEAN_GO);
    if (state_r == B_MEAN_GO) begin
      div_dvd = ELAPSED_W'({bytes_r, 8'h00});
      div_dvs = cnt_r;
    end else begin
      div_dvd = last_r - first_r;
      div_dvs = cnt_r - 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      win_r       <= 32'd1;
      cnt_r       <= '0;
      bytes_r     <= '0;
      src_used_r  <= '0;
      dst_used_r  <= '0;
      uni_used_r  <= '0;
      ovf_r       <= 1'b0;
      phase_r     <= '0;
      scan_k_r    <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        B_CLEAR: begin
          cnt_r      <= '0;
          bytes_r    <= '0;
          src_used_r <= '0;
          dst_used_r <= '0;
          uni_used_r <= '0;
          ovf_r      <= 1'b0;
          win_r      <= (cmd_r.op == OP_FLUSH) ? 32'd1 : cmd_r.win;
        end
        B_ADD: begin
          if (&cnt_r) ovf_r <= 1'b1;
          else        cnt_r <= cnt_r + 32'd1;
          if (bsum[32]) begin
            bytes_r <= 32'hFFFF_FFFF;
            ovf_r   <= 1'b1;
          end else begin
            bytes_r <= bsum[31:0];
          end
          phase_r  <= '0;
          scan_k_r <= '0;
          rd_v_r   <= 1'b0;
        end
        B_SCAN: begin
          rd_v_r <= issue;
          if (issue) scan_k_r <= scan_k_r + 1'b1;
          if (phase_end) begin
            phase_r  <= phase_r + 2'd1;
            scan_k_r <= '0;
            rd_v_r   <= 1'b0;
          end
          if (miss_done && !ins) ovf_r <= 1'b1;
          if (ins) begin
            case (phase_r)
              2'd0:    src_used_r <= src_used_r + 1'b1;
              2'd1:    dst_used_r <= dst_used_r + 1'b1;
              default: uni_used_r <= uni_used_r + 1'b1;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cmd_r <= head;
    if (state_r == B_ADD) begin
      if (cnt_r == '0) first_r <= cmd_r.elapsed;
      last_r <= cmd_r.elapsed;
    end
    if (state_r == B_GAP_GO && !gap_need) gap_r <= '0;
    if (state_r == B_GAP_WAIT && div_done)
      gap_r <= (|q[ELAPSED_W-1:26]) ? 26'h3FF_FFFF : q[25:0];
    if (state_r == B_MEAN_WAIT && div_done) mean_r <= q[23:0];
    if (out_load) begin
      out_word_r.window_index          <= win_r;
      out_word_r.packet_count          <= cnt_r;
      out_word_r.byte_total            <= bytes_r;
      out_word_r.mean_length_q8        <= mean_r;
      out_word_r.mean_gap_us           <= gap_r;
      out_word_r.distinct_sources      <= su32[8:0];
      out_word_r.distinct_destinations <= du32[8:0];
      out_word_r.distinct_addresses    <= uu32[9:0];
      out_word_r.overflow              <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ins && phase_r == 2'd0) src_mem[src_used_r[SIW-1:0]] <= key;
    if (ins && phase_r == 2'd1) dst_mem[dst_used_r[SIW-1:0]] <= key;
    if (ins && phase_r[1])      uni_mem[uni_used_r[UIW-1:0]] <= key;
    src_rd_r <= src_mem[scan_k_r[SIW-1:0]];
    dst_rd_r <= dst_mem[scan_k_r[SIW-1:0]];
    uni_rd_r <= uni_mem[scan_k_r[UIW-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_src_bound: assert property (@(posedge clk) disable iff (!rst_n)
    src_used_r <= SUW'(SET_DEPTH)) else $error("source set count beyond depth");
  a_uni_bound: assert property (@(posedge clk) disable iff (!rst_n)
    uni_used_r <= UUW'(UNION_DEPTH)) else $error("union set count beyond depth");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> scan_k_r < depth_sel) else $error("set scan past depth");

endmodule

/* rtl/per_window_traffic_statistics.sv */
// ----------------------------------------------------------------------------
// per_window_traffic_statistics
// Per-window packet, byte, timing and distinct-address statistics.
// ----------------------------------------------------------------------------
// Input words (packet record or end-of-capture) enter on in_valid/in_stall;
// one statistics word per closed window leaves on out_valid/out_stall.
// cfg_we/cfg_wdata set the window length in microseconds (0 acts as 1);
// write it only while the block is idle.
// The front stage takes one packet word at a time, in_stall high until done:
// elapsed time (multiply, add, sign check), a 52-step window-number division,
// then classify and queue; an end-of-capture word is queued straight away.
// Commands queue (4 deep) to the back stage, which pops, decodes and updates
// counters and then, per address set lookup, scans the stored entries in
// turn (four lookups per packet). Closing a window takes two divisions (a
// zero gap skips the first) before the result is registered; a packet in a
// later window closes and then joins.
// Reset clears all counters, sets and the queue; window length becomes
// 1000000. A stalled output holds its word; the back stage waits on it and
// the queue fills, then in_stall rises.
// ----------------------------------------------------------------------------
module per_window_traffic_statistics #(
  parameter int SET_DEPTH   = 256,
  parameter int UNION_DEPTH = 512
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pwts_pkg::in_word_t          in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pwts_pkg::out_word_t         out_word,
  input  logic                        cfg_we,
  input  logic [pwts_pkg::WLEN_W-1:0] cfg_wdata
);
  import pwts_pkg::*;

  q_wr_t   q_wr;
  q_stat_t q_stat;
  cmd_t    q_head;
  logic    q_pop;

  pwts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_wr      (q_wr),
    .q_stat    (q_stat)
  );

  pwts_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  pwts_back #(.SET_DEPTH(SET_DEPTH), .UNION_DEPTH(UNION_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for per_window_traffic_statistics. A directed table of
// packet records, flushes and window-length writes (window number saturation
// included) is followed by random capture sessions: advancing time with
// out-of-order and earlier packets, window skips and a session that fills the
// address sets. A behavioral copy of the window statistics predicts every
// closed-window word; outputs are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  import pwts_pkg::*;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;
  typedef enum logic {KIND_PKT = 1'b0, KIND_FLUSH = 1'b1} word_kind_t;

  typedef struct {
    row_kind_t   rk;
    in_word_t    w;
    bit          has_exp;
    out_word_t   exp;
    logic [25:0] wl;
  } dir_row_t;

  localparam longint US_SEC     = 1000000;
  localparam int     SRC_DEPTH  = 256;
  localparam int     UNI_DEPTH  = 512;
  localparam int     DRAIN_CYC  = 3000;
  localparam int     HOLD_CYC   = 3000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        cfg_we;
  logic [25:0] cfg_wdata;

  per_window_traffic_statistics dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // window statistics state
  logic [25:0] win_len;
  bit          sess_started;
  logic [31:0] base_s;
  logic [19:0] base_us;
  logic [31:0] cur_win;
  logic [31:0] pkt_cnt;
  logic [31:0] byte_acc;
  longint unsigned first_us;
  longint unsigned last_us;
  logic [31:0] src_set [SRC_DEPTH];
  logic [31:0] dst_set [SRC_DEPTH];
  logic [31:0] uni_set [UNI_DEPTH];
  int          src_n, dst_n, uni_n;
  bit          ovf;

  out_word_t   window_q[$];
  dir_row_t    dir_q[$];
  int          fails;
  bit          quiet;
  bit          hold_req;
  logic [31:0] addr_pool [8];

  function automatic void clear_stats();
    sess_started = 0;
    base_s = '0;
    base_us = '0;
    cur_win = 32'd1;
    pkt_cnt = '0;
    byte_acc = '0;
    first_us = 0;
    last_us = 0;
    src_n = 0;
    dst_n = 0;
    uni_n = 0;
    ovf = 0;
  endfunction

  function automatic void set_add(int which, logic [31:0] a);
    int depth;
    int used;
    logic [31:0] v;
    depth = (which == 2) ? UNI_DEPTH : SRC_DEPTH;
    used = (which == 0) ? src_n : (which == 1) ? dst_n : uni_n;
    for (int k = 0; k < used; k++) begin
      case (which)
        0: v = src_set[k];
        1: v = dst_set[k];
        default: v = uni_set[k];
      endcase
      if (v == a) return;
    end
    if (used < depth) begin
      case (which)
        0: begin src_set[used] = a; src_n++; end
        1: begin dst_set[used] = a; dst_n++; end
        default: begin uni_set[used] = a; uni_n++; end
      endcase
    end else begin
      ovf = 1;
    end
  endfunction

  function automatic void add_pkt(longint unsigned el, in_word_t w);
    if (pkt_cnt == 0) first_us = el;
    last_us = el;
    if (pkt_cnt == 32'hFFFF_FFFF) ovf = 1;
    else pkt_cnt++;
    if (longint'(byte_acc) + longint'(w.pkt_len) > 64'hFFFF_FFFF) begin
      byte_acc = 32'hFFFF_FFFF;
      ovf = 1;
    end else begin
      byte_acc += 32'(w.pkt_len);
    end
    set_add(0, w.src_ip);
    set_add(1, w.dst_ip);
    set_add(2, w.src_ip);
    set_add(2, w.dst_ip);
  endfunction

  function automatic bit close_window(output out_word_t r);
    longint unsigned gap;
    longint unsigned m;
    gap = 0;
    r = '0;
    if (pkt_cnt == 0) return 0;
    if (pkt_cnt > 1 && last_us > first_us)
      gap = (last_us - first_us) / longint'(pkt_cnt - 32'd1);
    if (gap > 64'h3FF_FFFF) gap = 64'h3FF_FFFF;
    m = (longint'(byte_acc) << 8) / longint'(pkt_cnt);
    r.window_index = cur_win;
    r.packet_count = pkt_cnt;
    r.byte_total = byte_acc;
    r.mean_length_q8 = m[23:0];
    r.mean_gap_us = gap[25:0];
    r.distinct_sources = src_n[8:0];
    r.distinct_destinations = dst_n[8:0];
    r.distinct_addresses = uni_n[9:0];
    r.overflow = ovf;
    return 1;
  endfunction

  function automatic bit predict_window(in_word_t w, output out_word_t r);
    longint diff;
    longint unsigned el;
    longint unsigned wl;
    longint unsigned widx;
    logic [31:0] win;
    bit n;
    r = '0;
    wl = (win_len == 0) ? 1 : longint'(win_len);
    if (w.kind == KIND_FLUSH) begin
      n = close_window(r);
      clear_stats();
      return n;
    end
    if (!sess_started) begin
      sess_started = 1;
      base_s = w.ts_seconds;
      base_us = w.ts_micros;
      cur_win = 32'd1;
    end
    diff = (longint'(w.ts_seconds) - longint'(base_s)) * US_SEC
         + (longint'(w.ts_micros) - longint'(base_us));
    if (diff < 0) return 0;
    el = diff;
    widx = el / wl + 1;
    win = (widx > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : widx[31:0];
    if (win < cur_win) return 0;
    if (win == cur_win) begin
      add_pkt(el, w);
      return 0;
    end
    n = close_window(r);
    cur_win = win;
    pkt_cnt = '0;
    byte_acc = '0;
    src_n = 0;
    dst_n = 0;
    uni_n = 0;
    ovf = 0;
    add_pkt(el, w);
    return n;
  endfunction

  task automatic send_word(in_word_t w, bit has_exp, out_word_t texp);
    bit st;
    out_word_t r;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
    end while (st);
    if (predict_window(w, r)) window_q = {window_q, (has_exp ? texp : r)};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (window_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_wlen(logic [25:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_len = v;
  endtask

  function automatic in_word_t mk_word(word_kind_t k, logic [31:0] s, logic [19:0] us,
                                       logic [15:0] len, logic [31:0] sa, logic [31:0] da);
    in_word_t w;
    w.kind = k;
    w.ts_seconds = s;
    w.ts_micros = us;
    w.pkt_len = len;
    w.src_ip = sa;
    w.dst_ip = da;
    return w;
  endfunction

  function automatic void add_row(in_word_t w);
    dir_row_t d;
    d.rk = ROW_WORD;
    d.w = w;
    d.has_exp = 0;
    d.exp = '0;
    d.wl = '0;
    dir_q = {dir_q, d};
  endfunction

  function automatic void add_cfg_row(logic [25:0] v);
    dir_row_t d;
    d.rk = ROW_CFG;
    d.w = '0;
    d.has_exp = 0;
    d.exp = '0;
    d.wl = v;
    dir_q = {dir_q, d};
  endfunction

  function automatic void build_table();
    dir_row_t d;
    add_row(mk_word(KIND_FLUSH, '1, '1, '1, '1, '1));
    add_row(mk_word(KIND_PKT, 32'd0, 20'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'd0));
    d.rk = ROW_WORD;
    d.w = mk_word(KIND_FLUSH, 32'd0, 20'd0, 16'd0, 32'd0, 32'd0);
    d.has_exp = 1;
    d.exp = '{32'd1, 32'd1, 32'd65535, 24'd16776960, 26'd0, 9'd1, 9'd1, 10'd2, 1'b0};
    d.wl = '0;
    dir_q = {dir_q, d};
    add_row(mk_word(KIND_PKT, 32'd100, 20'd999999, 16'd0, 32'h0A00_0001, 32'h0A00_0001));
    add_row(mk_word(KIND_PKT, 32'd100, 20'd500000, 16'd64, 32'h0A00_0002, 32'h0A00_0003));
    add_row(mk_word(KIND_PKT, 32'd101, 20'd0, 16'd1500, 32'h0A00_0002, 32'h0A00_0001));
    add_row(mk_word(KIND_PKT, 32'd101, 20'd999998, 16'd40, 32'hC0A8_0001, 32'h0A00_0002));
    add_row(mk_word(KIND_PKT, 32'd102, 20'd500000, 16'd9000, 32'hC0A8_0001, 32'hC0A8_0002));
    add_row(mk_word(KIND_PKT, 32'd102, 20'd0, 16'd100, 32'hC0A8_0003, 32'hC0A8_0002));
    add_row(mk_word(KIND_PKT, 32'd50, 20'd0, 16'd1, 32'h1, 32'h2));
    add_row(mk_word(KIND_PKT, 32'd103, 20'hFFFFF, 16'd77, 32'h5555_5555, 32'hAAAA_AAAA));
    add_row(mk_word(KIND_FLUSH, 32'd0, 20'd0, 16'd0, 32'd0, 32'd0));
    add_cfg_row(26'd0);
    add_row(mk_word(KIND_PKT, 32'd0, 20'd0, 16'd10, 32'h1, 32'h2));
    add_row(mk_word(KIND_PKT, 32'd0, 20'd3, 16'd20, 32'h3, 32'h4));
    add_row(mk_word(KIND_PKT, 32'hFFFF_FFFF, 20'd999999, 16'd30, 32'h5, 32'h6));
    add_row(mk_word(KIND_PKT, 32'hFFFF_FFFF, 20'hFFFFF, 16'd40, 32'h5, 32'h7));
    add_row(mk_word(KIND_FLUSH, 32'd0, 20'd0, 16'd0, 32'd0, 32'd0));
    add_cfg_row(26'd60000000);
    add_row(mk_word(KIND_PKT, 32'd5, 20'd0, 16'd1, 32'h8, 32'h9));
    add_row(mk_word(KIND_PKT, 32'd64, 20'd999999, 16'd2, 32'h9, 32'h8));
    add_row(mk_word(KIND_PKT, 32'd65, 20'd0, 16'd3, 32'h8, 32'h8));
    add_row(mk_word(KIND_FLUSH, 32'd0, 20'd0, 16'd0, 32'd0, 32'd0));
  endfunction

  task automatic run_session(int n, int pause_at);
    longint t;
    longint wl;
    longint delta;
    in_word_t w;
    out_word_t nx;
    logic [31:0] s;
    logic [19:0] us;
    nx = '0;
    wl = (win_len == 0) ? 1 : longint'(win_len);
    t = longint'($urandom) * US_SEC + $urandom_range(0, 999999);
    for (int k = 0; k < 8; k++) addr_pool[k] = $urandom;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) begin
        in_valid <= 1'b0;
        while (window_q.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 99) < 4) begin
        w = mk_word(KIND_FLUSH, $urandom, 20'($urandom), 16'($urandom), $urandom, $urandom);
        t = longint'($urandom) * US_SEC + $urandom_range(0, 999999);
      end else begin
        case ($urandom_range(0, 9))
          0: delta = 0;
          1, 2, 3, 4: delta = $urandom_range(0, int'(wl - 1));
          5, 6, 7: delta = wl + $urandom_range(0, int'(wl));
          8: delta = wl * $urandom_range(2, 5);
          default: delta = -longint'($urandom_range(1, int'(wl)));
        endcase
        t += delta;
        if (t < 0) t = 0;
        s = 32'(t / US_SEC);
        us = 20'(t % US_SEC);
        if ($urandom_range(0, 19) == 0) us = 20'($urandom);
        w = mk_word(KIND_PKT, s, us, 16'($urandom),
                    ($urandom_range(0, 7) == 0) ? $urandom : addr_pool[$urandom_range(0, 7)],
                    ($urandom_range(0, 7) == 0) ? $urandom : addr_pool[$urandom_range(0, 7)]);
      end
      send_word(w, 0, nx);
    end
  endtask

  task automatic fill_sets(int n);
    logic [31:0] s0;
    out_word_t nx;
    nx = '0;
    s0 = $urandom_range(0, 32'h7FFF_FFFF);
    for (int i = 0; i < n; i++)
      send_word(mk_word(KIND_PKT, s0, 20'(i), 16'($urandom), 32'hA500_0000 | i,
                        32'h5A00_0000 | i), 0, nx);
    send_word(mk_word(KIND_FLUSH, '0, '0, '0, '0, '0), 0, nx);
  endtask

  initial begin
    bit v, st;
    out_word_t w;
    out_word_t e;
    forever begin
      @(negedge clk);
      v = out_valid;
      st = out_stall;
      w = out_word;
      @(posedge clk);
      if (v && !st) begin
        if (window_q.size() == 0) begin
          $error("unexpected window word %p", w);
          fails++;
        end else begin
          e = window_q.pop_front();
          if (w.window_index !== e.window_index) begin
            $error("window_index exp %0d got %0d", e.window_index, w.window_index); fails++;
          end
          if (w.packet_count !== e.packet_count) begin
            $error("packet_count exp %0d got %0d", e.packet_count, w.packet_count); fails++;
          end
          if (w.byte_total !== e.byte_total) begin
            $error("byte_total exp %0d got %0d", e.byte_total, w.byte_total); fails++;
          end
          if (w.mean_length_q8 !== e.mean_length_q8) begin
            $error("mean_length_q8 exp %0d got %0d", e.mean_length_q8, w.mean_length_q8);
            fails++;
          end
          if (w.mean_gap_us !== e.mean_gap_us) begin
            $error("mean_gap_us exp %0d got %0d", e.mean_gap_us, w.mean_gap_us); fails++;
          end
          if (w.distinct_sources !== e.distinct_sources) begin
            $error("distinct_sources exp %0d got %0d", e.distinct_sources,
                   w.distinct_sources); fails++;
          end
          if (w.distinct_destinations !== e.distinct_destinations) begin
            $error("distinct_destinations exp %0d got %0d", e.distinct_destinations,
                   w.distinct_destinations); fails++;
          end
          if (w.distinct_addresses !== e.distinct_addresses) begin
            $error("distinct_addresses exp %0d got %0d", e.distinct_addresses,
                   w.distinct_addresses); fails++;
          end
          if (w.overflow !== e.overflow) begin
            $error("overflow exp %0d got %0d", e.overflow, w.overflow); fails++;
          end
        end
      end
    end
  end

  // receiver hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #40_000_000;
    $display("[per_window_traffic_statistics] ERROR");
    $finish;
  end

  initial begin
    dir_row_t d;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    fails = 0;
    quiet = 0;
    hold_req = 0;
    win_len = WLEN_RESET;
    clear_stats();
    build_table();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_q[i]) begin
      d = dir_q[i];
      if (d.rk == ROW_CFG) write_wlen(d.wl);
      else send_word(d.w, d.has_exp, d.exp);
    end
    write_wlen(26'd1000);
    hold_req = 1;
    run_session(50, -1);
    write_wlen(26'd1);
    run_session(40, -1);
    write_wlen(26'd1000000);
    run_session(50, 30);
    write_wlen(26'd60000000);
    fill_sets(262);
    write_wlen(26'($urandom_range(1, 60000000)));
    quiet = 1;
    run_session(30, -1);
    drain();
    if (fails == 0) $display("[per_window_traffic_statistics] OK");
    else $display("[per_window_traffic_statistics] ERROR");
    $finish;
  end

endmodule
